// ----- design/sir_pkg.sv -----
// Shared types, widths and codes for the sorted id registry.
package sir_pkg;

    // Built table depth and the widths that follow from it
    localparam int TABLE_DEPTH = 64;
    localparam int POS_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // Fixed field widths
    localparam int ID_W       = 64;
    localparam int REF_W      = 64;
    localparam int COUNT_W    = 32;
    localparam int CMD_W      = 2;
    localparam int STATUS_W   = 3;
    localparam int IDX_W      = 6;
    localparam int ECNT_W     = 7;
    localparam int CAP_W      = 7;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 64;
    localparam int CMP_W      = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    // Reset values of the configuration registers
    localparam logic [CAP_W-1:0] CAP_RESET     = CAP_W'(64);
    localparam logic [ID_W-1:0]  AUTO_ID_RESET = ID_W'(1);

    // Command codes
    localparam logic [CMD_W-1:0] CMD_FIND       = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REGISTER   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SET_COUNTS = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY_LIMIT = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_AUTO_ID  = 8'd1;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK        = 3'd0,
        STS_FULL      = 3'd1,
        STS_DUPLICATE = 3'd2,
        STS_NOT_FOUND = 3'd3,
        STS_REFINED   = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    // One table record
    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [REF_W-1:0]   group_ref;
        logic [REF_W-1:0]   policy_ref;
        logic [COUNT_W-1:0] group_size;
        logic [COUNT_W-1:0] refined_size;
        logic [REF_W-1:0]   source_ref;
    } rec_t;

    // One finished result
    typedef struct packed {
        status_t           status;
        logic [IDX_W-1:0]  entry_index;
        rec_t              rec;
        logic [ECNT_W-1:0] entry_count;
    } result_t;

endpackage

// ----- design/sorted_id_registry_core.sv -----
// A find, register or set counts transaction makes one full trip of the record ring past
// the head sequencer, one slot per cycle.
// A full-table register or an unused command answers without a scan.
// One transaction is in work at a time; a result waits in the output register meanwhile.
// Reset (aresetn, synchronous, active low) empties the table, sets capacity_limit to 64
// and the automatic id counter to one. Writing first_auto_id empties the table as well.
module sorted_id_registry_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [sir_pkg::CMD_W-1:0]        s_command,
    input  logic [sir_pkg::ID_W-1:0]         s_agent_id,
    input  logic [sir_pkg::REF_W-1:0]        s_group_ref,
    input  logic [sir_pkg::REF_W-1:0]        s_policy_ref,
    input  logic [sir_pkg::COUNT_W-1:0]      s_group_size,
    input  logic [sir_pkg::COUNT_W-1:0]      s_refined_size,
    input  logic [sir_pkg::REF_W-1:0]        s_source_ref,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [sir_pkg::STATUS_W-1:0]     m_status,
    output logic [sir_pkg::IDX_W-1:0]        m_entry_index,
    output logic [sir_pkg::ID_W-1:0]         m_result_id,
    output logic [sir_pkg::REF_W-1:0]        m_out_group_ref,
    output logic [sir_pkg::REF_W-1:0]        m_out_policy_ref,
    output logic [sir_pkg::COUNT_W-1:0]      m_out_group_size,
    output logic [sir_pkg::COUNT_W-1:0]      m_out_refined_size,
    output logic [sir_pkg::REF_W-1:0]        m_out_source_ref,
    output logic [sir_pkg::ECNT_W-1:0]       m_entry_count,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [sir_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sir_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import sir_pkg::*;

    rec_t    cell_rec [TABLE_DEPTH];
    rec_t    tail_rec;
    logic    shift_en;
    logic    res_valid;
    logic    res_take;
    result_t res;

    logic    m_valid_reg, m_valid_next;
    result_t m_res_reg, m_res_next;

    sir_ctrl u_ctrl (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_command        (s_command),
        .s_agent_id       (s_agent_id),
        .s_group_ref      (s_group_ref),
        .s_policy_ref     (s_policy_ref),
        .s_group_size     (s_group_size),
        .s_refined_size   (s_refined_size),
        .s_source_ref     (s_source_ref),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .head_rec         (cell_rec[0]),
        .tail_rec         (tail_rec),
        .shift_en         (shift_en),
        .res_valid        (res_valid),
        .res_take         (res_take),
        .res              (res)
    );

    // Chain of cells: each takes its upper neighbor, the last takes the sequencer's tail
    for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
        if (i == TABLE_DEPTH - 1) begin : g_last
            sir_cell u_cell (
                .aclk     (aclk),
                .shift_en (shift_en),
                .rec_in   (tail_rec),
                .rec_out  (cell_rec[i])
            );
        end else begin : g_mid
            sir_cell u_cell (
                .aclk     (aclk),
                .shift_en (shift_en),
                .rec_in   (cell_rec[i+1]),
                .rec_out  (cell_rec[i])
            );
        end
    end

    // Move a finished result into the output register when it is free
    always_comb begin
        res_take     = res_valid && (!m_valid_reg || m_ready);
        m_valid_next = m_valid_reg;
        m_res_next   = m_res_reg;
        if (res_take) begin
            m_valid_next = 1'b1;
            m_res_next   = res;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_res_reg <= m_res_next;
    end

    assign m_valid            = m_valid_reg;
    assign m_status           = m_res_reg.status;
    assign m_entry_index      = m_res_reg.entry_index;
    assign m_result_id        = m_res_reg.rec.id;
    assign m_out_group_ref    = m_res_reg.rec.group_ref;
    assign m_out_policy_ref   = m_res_reg.rec.policy_ref;
    assign m_out_group_size   = m_res_reg.rec.group_size;
    assign m_out_refined_size = m_res_reg.rec.refined_size;
    assign m_out_source_ref   = m_res_reg.rec.source_ref;
    assign m_entry_count      = m_res_reg.entry_count;

endmodule

// ----- design/sir_cell.sv -----
// One storage cell of the record ring: holds a record and passes it down the chain.
module sir_cell (
    input  logic          aclk,
    input  logic          shift_en,
    input  sir_pkg::rec_t rec_in,
    output sir_pkg::rec_t rec_out
);
    import sir_pkg::*;

    rec_t rec_reg;
    rec_t rec_next;

    // Take the neighbor's record on a shift, hold otherwise
    always_comb begin
        rec_next = shift_en ? rec_in : rec_reg;
    end

    always_ff @(posedge aclk) begin
        rec_reg <= rec_next;
    end

    assign rec_out = rec_reg;

endmodule

// ----- design/sir_ctrl.sv -----
// Sequencer at the head of the cell ring: search, insert, update and result building.
module sir_ctrl (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [sir_pkg::CMD_W-1:0]        s_command,
    input  logic [sir_pkg::ID_W-1:0]         s_agent_id,
    input  logic [sir_pkg::REF_W-1:0]        s_group_ref,
    input  logic [sir_pkg::REF_W-1:0]        s_policy_ref,
    input  logic [sir_pkg::COUNT_W-1:0]      s_group_size,
    input  logic [sir_pkg::COUNT_W-1:0]      s_refined_size,
    input  logic [sir_pkg::REF_W-1:0]        s_source_ref,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [sir_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sir_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  sir_pkg::rec_t                    head_rec,
    output sir_pkg::rec_t                    tail_rec,
    output logic                             shift_en,
    output logic                             res_valid,
    input  logic                             res_take,
    output sir_pkg::result_t                 res
);
    import sir_pkg::*;

    state_t state_reg, state_next;

    // Latched transaction
    logic [CMD_W-1:0]   cmd_reg, cmd_next;
    logic [ID_W-1:0]    key_reg, key_next;
    logic [REF_W-1:0]   cref_reg, cref_next;
    logic [REF_W-1:0]   dref_reg, dref_next;
    logic [COUNT_W-1:0] ccnt_reg, ccnt_next;
    logic [COUNT_W-1:0] rcnt_reg, rcnt_next;
    logic [REF_W-1:0]   pref_reg, pref_next;

    // Scan state
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             stop_reg, stop_next;
    logic             carry_act_reg, carry_act_next;
    rec_t             carry_reg, carry_next;

    // Table and configuration state
    logic [CNT_W-1:0] used_reg, used_next;
    logic [ID_W-1:0]  next_id_reg, next_id_next;
    logic [CAP_W-1:0] cap_reg, cap_next;

    // Pending result
    status_t          res_status_reg, res_status_next;
    logic [IDX_W-1:0] res_index_reg, res_index_next;
    rec_t             res_rec_reg, res_rec_next;

    logic             in_accept;
    logic             cfg_accept;
    logic [CMP_W-1:0] cap_eff;
    logic             table_full;
    logic             go_scan;
    logic [ID_W-1:0]  draw_id;
    logic             in_use;
    logic             look;
    logic             id_eq;
    logic             id_gt;
    logic             is_reg;
    logic             is_set;
    logic             hit_now;
    logic             stop_now;
    logic             ins_now;
    logic             set_ok;
    logic             last_pos;
    rec_t             new_rec;
    rec_t             mod_rec;
    rec_t             dup_rec;

    assign in_accept  = s_valid && s_ready;
    assign cfg_ready  = 1'b1;
    assign cfg_accept = cfg_valid && cfg_ready;

    // Clamp the capacity to the built depth and check for a full table
    always_comb begin
        cap_eff = (CMP_W'(cap_reg) > CMP_W'(TABLE_DEPTH)) ? CMP_W'(TABLE_DEPTH)
                                                           : CMP_W'(cap_reg);
        table_full = CMP_W'(used_reg) >= cap_eff;
        go_scan    = (s_command == CMD_FIND) || (s_command == CMD_SET_COUNTS) ||
                     ((s_command == CMD_REGISTER) && !table_full);
        // Skip zero when drawing an automatic id
        draw_id    = (next_id_reg == '0) ? next_id_reg + ID_W'(1) : next_id_reg;
    end

    // Compare the head record against the key
    always_comb begin
        in_use   = CNT_W'(pos_reg) < used_reg;
        look     = !stop_reg && in_use;
        id_eq    = head_rec.id == key_reg;
        id_gt    = head_rec.id > key_reg;
        is_reg   = cmd_reg == CMD_REGISTER;
        is_set   = cmd_reg == CMD_SET_COUNTS;
        hit_now  = look && id_eq;
        stop_now = !stop_reg && (!in_use || id_eq || id_gt);
        ins_now  = is_reg && !stop_reg && (!in_use || id_gt);
        set_ok   = is_set && hit_now && !(rcnt_reg > ccnt_reg);
        last_pos = pos_reg == POS_W'(TABLE_DEPTH - 1);

        new_rec.id           = key_reg;
        new_rec.group_ref    = cref_reg;
        new_rec.policy_ref   = dref_reg;
        new_rec.group_size   = ccnt_reg;
        new_rec.refined_size = '0;
        new_rec.source_ref   = (pref_reg != '0) ? pref_reg : key_reg;

        mod_rec              = head_rec;
        mod_rec.group_size   = ccnt_reg;
        mod_rec.refined_size = rcnt_reg;

        dup_rec    = '0;
        dup_rec.id = key_reg;
    end

    // Feed the tail: delayed records after an insert, else the new or updated record, else the head record
    always_comb begin
        if (carry_act_reg) begin
            tail_rec = carry_reg;
        end else if (ins_now) begin
            tail_rec = new_rec;
        end else if (set_ok) begin
            tail_rec = mod_rec;
        end else begin
            tail_rec = head_rec;
        end
    end

    // Next values of the datapath and table state
    always_comb begin
        cmd_next        = cmd_reg;
        key_next        = key_reg;
        cref_next       = cref_reg;
        dref_next       = dref_reg;
        ccnt_next       = ccnt_reg;
        rcnt_next       = rcnt_reg;
        pref_next       = pref_reg;
        pos_next        = pos_reg;
        stop_next       = stop_reg;
        carry_act_next  = carry_act_reg;
        carry_next      = carry_reg;
        used_next       = used_reg;
        next_id_next    = next_id_reg;
        cap_next        = cap_reg;
        res_status_next = res_status_reg;
        res_index_next  = res_index_reg;
        res_rec_next    = res_rec_reg;

        // Latch the transaction and draw an id when asked
        if (in_accept) begin
            cmd_next        = s_command;
            key_next        = s_agent_id;
            cref_next       = s_group_ref;
            dref_next       = s_policy_ref;
            ccnt_next       = s_group_size;
            rcnt_next       = s_refined_size;
            pref_next       = s_source_ref;
            pos_next        = '0;
            stop_next       = 1'b0;
            carry_act_next  = 1'b0;
            res_status_next = ((s_command == CMD_REGISTER) && table_full) ? STS_FULL
                                                                          : STS_NOT_FOUND;
            res_index_next  = '0;
            res_rec_next    = '0;
            if ((s_command == CMD_REGISTER) && !table_full && (s_agent_id == '0)) begin
                key_next     = draw_id;
                next_id_next = draw_id + ID_W'(1);
            end
        end

        // Walk the ring one slot per cycle
        if (state_reg == ST_SCAN) begin
            pos_next  = last_pos ? '0 : pos_reg + POS_W'(1);
            stop_next = stop_reg || stop_now;
            if (carry_act_reg || ins_now) begin
                carry_next     = head_rec;
                carry_act_next = 1'b1;
            end
            if (ins_now) begin
                used_next       = used_reg + CNT_W'(1);
                res_status_next = STS_OK;
                res_index_next  = IDX_W'(pos_reg);
                res_rec_next    = new_rec;
            end else if (hit_now) begin
                res_index_next = IDX_W'(pos_reg);
                if (is_reg) begin
                    res_status_next = STS_DUPLICATE;
                    res_rec_next    = dup_rec;
                end else if (is_set && !set_ok) begin
                    res_status_next = STS_REFINED;
                    res_rec_next    = head_rec;
                end else if (set_ok) begin
                    res_status_next = STS_OK;
                    res_rec_next    = mod_rec;
                end else begin
                    res_status_next = STS_OK;
                    res_rec_next    = head_rec;
                end
            end
        end

        // Configuration writes; a new first id empties the table
        if (cfg_accept) begin
            if (cfg_index == CFG_CAPACITY_LIMIT) begin
                cap_next = cfg_data[CAP_W-1:0];
            end else if (cfg_index == CFG_FIRST_AUTO_ID) begin
                used_next    = '0;
                next_id_next = (cfg_data == '0) ? ID_W'(1) : cfg_data;
            end
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    state_next = go_scan ? ST_SCAN : ST_DONE;
                end
            end
            ST_SCAN: begin
                if (last_pos) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (res_take) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        s_ready   = 1'b0;
        shift_en  = 1'b0;
        res_valid = 1'b0;
        unique case (state_reg)
            ST_IDLE: s_ready   = 1'b1;
            ST_SCAN: shift_en  = 1'b1;
            ST_DONE: res_valid = 1'b1;
            default: s_ready   = 1'b0;
        endcase
    end

    assign res.status      = res_status_reg;
    assign res.entry_index = res_index_reg;
    assign res.rec         = res_rec_reg;
    assign res.entry_count = ECNT_W'(used_reg);

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            stop_reg      <= 1'b0;
            carry_act_reg <= 1'b0;
            used_reg      <= '0;
            next_id_reg   <= AUTO_ID_RESET;
            cap_reg       <= CAP_RESET;
        end else begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            stop_reg      <= stop_next;
            carry_act_reg <= carry_act_next;
            used_reg      <= used_next;
            next_id_reg   <= next_id_next;
            cap_reg       <= cap_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        cmd_reg        <= cmd_next;
        key_reg        <= key_next;
        cref_reg       <= cref_next;
        dref_reg       <= dref_next;
        ccnt_reg       <= ccnt_next;
        rcnt_reg       <= rcnt_next;
        pref_reg       <= pref_next;
        carry_reg      <= carry_next;
        res_status_reg <= res_status_next;
        res_index_reg  <= res_index_next;
        res_rec_reg    <= res_rec_next;
    end

`ifndef SYNTH
    // The table never holds more records than the ring has cells
    a_used_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        CNT_W'(TABLE_DEPTH) >= used_reg)
        else $error("record count exceeds table depth");

    // A scan ends after exactly one trip around the ring
    a_scan_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) && last_pos |=> state_reg == ST_DONE)
        else $error("scan did not end on the last slot");

    // The delayed record path runs only once the insert point is passed
    a_carry_stop: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) && carry_act_reg |-> stop_reg)
        else $error("carry active before the insert point");

    // A register transaction never scans with a zero key
    a_key_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) && (cmd_reg == CMD_REGISTER) |-> key_reg != '0)
        else $error("register scan with zero id");

    // An insert grows the table by one record
    a_insert_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) && ins_now && !cfg_accept |=>
            used_reg == $past(used_reg) + CNT_W'(1))
        else $error("insert did not advance the record count");
`endif

endmodule
